### hdl/mstq_pkg.sv
// Shared constants and types of the multi-slot timer queue.
package mstq_pkg;

   // Slot count and derived widths
   localparam int NUM_TIMERS  = 16;
   localparam int SLOT_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CNT_W       = $clog2(NUM_TIMERS + 1);

   // Fixed field widths
   localparam int FUNC_W      = 2;
   localparam int ID_W        = 4;
   localparam int INTERVAL_W  = 32;
   localparam int NOW_W       = 64;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Function codes on the request port
   localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ADD  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_KILL = 2'd2;

   // Classified operation
   typedef enum logic [1:0] {
      OP_TICK = 2'd0,
      OP_ADD  = 2'd1,
      OP_KILL = 2'd2
   } op_type;

   // One queued command
   typedef struct packed {
      op_type                  op;
      logic [SLOT_W-1:0]       slot;
      logic                    periodic;
      logic [INTERVAL_W-1:0]   interval;
   } cmd_type;

   // Queue status seen by front and back
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

### hdl/mstq_front.sv
// Front end: decodes requests and drops those with an unused function code or an id beyond the slots.
module mstq_front (
   input  logic                           start,
   input  logic [mstq_pkg::FUNC_W-1:0]    req_func,
   input  logic [mstq_pkg::ID_W-1:0]      req_timer_id,
   input  logic                           req_periodic,
   input  logic [mstq_pkg::INTERVAL_W-1:0] req_interval_ms,
   input  mstq_pkg::q_status_type         q_status,
   output logic                           busy,
   output logic                           push,
   output mstq_pkg::cmd_type              push_cmd
);
   import mstq_pkg::*;

   logic keep;
   logic id_ok;

   // Id must name an existing slot
   assign id_ok = (32'(req_timer_id) < 32'(NUM_TIMERS));

   // Classify the request
   always_comb begin
      keep              = 1'b0;
      push_cmd.op       = OP_TICK;
      push_cmd.slot     = SLOT_W'(req_timer_id);
      push_cmd.periodic = req_periodic;
      push_cmd.interval = req_interval_ms;
      unique case (req_func) inside
         FUNC_TICK: begin
            keep = 1'b1;
         end
         FUNC_ADD, FUNC_KILL: begin
            keep        = id_ok;
            push_cmd.op = (req_func == FUNC_ADD) ? OP_ADD : OP_KILL;
         end
         default: begin
            keep = 1'b0;   // unused code: transfer taken, nothing queued
         end
      endcase
   end

   assign busy = q_status.full;
   assign push = start && !q_status.full && keep;

endmodule

### hdl/mstq_queue.sv
// Short command queue that decouples the front end from the engine.
module mstq_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  mstq_pkg::cmd_type      push_cmd,
   input  logic                   pop,
   output mstq_pkg::cmd_type      pop_cmd,
   output mstq_pkg::q_status_type q_status
);
   import mstq_pkg::*;

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff,  count_in;
   logic               do_push;
   logic               do_pop;

   assign q_status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign do_push        = push && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign pop_cmd        = entry_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### hdl/mstq_back.sv
// Engine: slot store, millisecond clock and the ordered expiry scan.
module mstq_back (
   input  logic                     clock,
   input  logic                     reset,
   input  mstq_pkg::q_status_type   q_status,
   input  mstq_pkg::cmd_type        cmd,
   output logic                     pop,
   output logic                     rsp_strobe,
   output logic [mstq_pkg::ID_W-1:0] rsp_fired_id,
   output logic                     rsp_last
);
   import mstq_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type               state_ff, state_in;
   logic [NOW_W-1:0]        now_ff, now_in;
   logic [NUM_TIMERS-1:0]   active_ff, active_in;
   logic [NUM_TIMERS-1:0]   periodic_ff, periodic_in;
   logic [NUM_TIMERS-1:0]   pend_ff, pend_in;
   logic [SLOT_W-1:0]       idx_ff, idx_in;
   logic                    first_ff, first_in;
   logic                    found_ff, found_in;
   logic [SLOT_W-1:0]       best_ff, best_in;
   logic [NOW_W-1:0]        best_dl_ff, best_dl_in;
   logic [CNT_W-1:0]        remain_ff, remain_in;
   logic                    strobe_ff, strobe_in;
   logic [ID_W-1:0]         fired_ff, fired_in;
   logic                    last_ff, last_in;

   logic [INTERVAL_W-1:0]   interval_ff [NUM_TIMERS];
   logic [NOW_W-1:0]        deadline_ff [NUM_TIMERS];

   logic                    dl_wr;
   logic                    ivl_wr;
   logic [SLOT_W-1:0]       wr_addr;
   logic [INTERVAL_W-1:0]   add_ivl;
   logic [NOW_W-1:0]        dl_sum;
   logic [NOW_W-1:0]        scan_dl;
   logic                    due_now;
   logic                    cand;
   logic                    better;
   logic                    idx_last;

   // Deadline adder shared by add and re-arm
   assign add_ivl = (state_ff == ST_EMIT) ? interval_ff[best_ff] : cmd.interval;
   assign dl_sum  = now_ff + NOW_W'(add_ivl);
   assign wr_addr = (state_ff == ST_EMIT) ? best_ff : cmd.slot;

   // Scan datapath: one slot per cycle
   assign scan_dl  = deadline_ff[idx_ff];
   assign due_now  = active_ff[idx_ff] && (scan_dl <= now_ff);
   assign cand     = first_ff ? due_now : pend_ff[idx_ff];
   assign better   = cand && (!found_ff || (scan_dl < best_dl_ff));
   assign idx_last = (idx_ff == SLOT_W'(NUM_TIMERS - 1));

   assign pop = (state_ff == ST_IDLE) && !q_status.empty;

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      now_in      = now_ff;
      active_in   = active_ff;
      periodic_in = periodic_ff;
      pend_in     = pend_ff;
      idx_in      = idx_ff;
      first_in    = first_ff;
      found_in    = found_ff;
      best_in     = best_ff;
      best_dl_in  = best_dl_ff;
      remain_in   = remain_ff;
      strobe_in   = 1'b0;
      fired_in    = fired_ff;
      last_in     = 1'b0;
      dl_wr       = 1'b0;
      ivl_wr      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               unique case (cmd.op)
                  OP_TICK: begin
                     now_in    = now_ff + 1'b1;
                     state_in  = ST_SCAN;
                     idx_in    = '0;
                     first_in  = 1'b1;
                     found_in  = 1'b0;
                     remain_in = '0;
                  end
                  OP_ADD: begin
                     if (!active_ff[cmd.slot]) begin
                        active_in[cmd.slot]   = 1'b1;
                        periodic_in[cmd.slot] = cmd.periodic;
                        dl_wr                 = 1'b1;
                        ivl_wr                = 1'b1;
                     end
                  end
                  OP_KILL: begin
                     active_in[cmd.slot] = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // first pass marks due slots and counts them
            if (first_ff) begin
               pend_in[idx_ff] = due_now;
               if (due_now) begin
                  remain_in = remain_ff + 1'b1;
               end
            end
            // strict compare: ties keep the lower id
            if (better) begin
               found_in   = 1'b1;
               best_in    = idx_ff;
               best_dl_in = scan_dl;
            end
            if (idx_last) begin
               idx_in   = '0;
               first_in = 1'b0;
               state_in = (found_ff || better) ? ST_EMIT : ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            strobe_in        = 1'b1;
            fired_in         = ID_W'(best_ff);
            last_in          = (remain_ff == CNT_W'(1));
            remain_in        = remain_ff - 1'b1;
            pend_in[best_ff] = 1'b0;
            found_in         = 1'b0;
            if (periodic_ff[best_ff]) begin
               dl_wr = 1'b1;
            end else begin
               active_in[best_ff] = 1'b0;
            end
            state_in = (remain_ff == CNT_W'(1)) ? ST_IDLE : ST_SCAN;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         now_ff      <= '0;
         active_ff   <= '0;
         periodic_ff <= '0;
         pend_ff     <= '0;
         idx_ff      <= '0;
         first_ff    <= 1'b0;
         found_ff    <= 1'b0;
         remain_ff   <= '0;
         strobe_ff   <= 1'b0;
         last_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         now_ff      <= now_in;
         active_ff   <= active_in;
         periodic_ff <= periodic_in;
         pend_ff     <= pend_in;
         idx_ff      <= idx_in;
         first_ff    <= first_in;
         found_ff    <= found_in;
         remain_ff   <= remain_in;
         strobe_ff   <= strobe_in;
         last_ff     <= last_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      best_ff    <= best_in;
      best_dl_ff <= best_dl_in;
      fired_ff   <= fired_in;
   end

   // Slot store
   always_ff @(posedge clock) begin
      if (dl_wr) begin
         deadline_ff[wr_addr] <= dl_sum;
      end
      if (ivl_wr) begin
         interval_ff[wr_addr] <= cmd.interval;
      end
   end

   assign rsp_strobe   = strobe_ff;
   assign rsp_fired_id = fired_ff;
   assign rsp_last     = last_ff;

endmodule

### hdl/multi_slot_timer_queue_unit.sv
// Top level of the multi-slot timer queue: front end, command queue, engine.
//
//   channel   ports                                   transfer when
//   request   start, busy, req_func, req_timer_id,    start && !busy
//             req_periodic, req_interval_ms
//   result    rsp_strobe, rsp_fired_id, rsp_last      rsp_strobe (one cycle each)
//
// Add and kill are handled in the idle state. A tick advances the millisecond clock;
// the expiry scan then reads one slot of the deadline store per cycle and needs one
// full pass over all slots per result.
// A two-entry command queue lets requests be taken while the engine scans;
// busy is high only while that queue is full.
// Reset is synchronous and active high; it clears the clock, all slots and the queue.
// The receiver cannot stall: each result stands for exactly one cycle.
module multi_slot_timer_queue_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [mstq_pkg::FUNC_W-1:0]     req_func,
   input  logic [mstq_pkg::ID_W-1:0]       req_timer_id,
   input  logic                            req_periodic,
   input  logic [mstq_pkg::INTERVAL_W-1:0] req_interval_ms,
   output logic                            rsp_strobe,
   output logic [mstq_pkg::ID_W-1:0]       rsp_fired_id,
   output logic                            rsp_last
);
   import mstq_pkg::*;

   q_status_type q_status;
   logic         push;
   cmd_type      push_cmd;
   logic         pop;
   cmd_type      pop_cmd;

   mstq_front u_front (
      .start           (start),
      .req_func        (req_func),
      .req_timer_id    (req_timer_id),
      .req_periodic    (req_periodic),
      .req_interval_ms (req_interval_ms),
      .q_status        (q_status),
      .busy            (busy),
      .push            (push),
      .push_cmd        (push_cmd)
   );

   mstq_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .q_status (q_status)
   );

   mstq_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_status     (q_status),
      .cmd          (pop_cmd),
      .pop          (pop),
      .rsp_strobe   (rsp_strobe),
      .rsp_fired_id (rsp_fired_id),
      .rsp_last     (rsp_last)
   );

endmodule

### hdl/mstq_checker.sv
// Port-level checks of the timer queue and their binding to the top level.
module mstq_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            busy,
   input  logic                            rsp_strobe,
   input  logic [mstq_pkg::ID_W-1:0]       rsp_fired_id,
   input  logic                            rsp_last
);

   // Last marker only travels with a result
   a_last_with_strobe: assert property (@(posedge clock)
      !rsp_strobe |-> !rsp_last)
      else $error("rsp_last high without rsp_strobe");

   // Out of reset the queue is empty and no result is pending
   a_reset_clean: assert property (@(posedge clock)
      $past(reset) |-> (!busy && !rsp_strobe))
      else $error("busy or result present right after reset");

   // Each result needs a fresh scan pass, so results never come back to back
   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two results in consecutive cycles");

   // A slot beyond the supported ids never fires
   a_fired_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (32'(rsp_fired_id) < 32'(mstq_pkg::NUM_TIMERS)))
      else $error("fired id outside the slot range");

endmodule

bind multi_slot_timer_queue_unit mstq_checker u_checker (.*);
